// ===== rtl/usbcdb_pkg.sv =====
// Package for the control-transfer descriptor builder.
// Holds stage codes, token and status constants, the sequencer state type and
// the control bundle passed to the word formatter. No dependencies.
package usbcdb_pkg;

   localparam int MAX_DESCRIPTORS = 32;
   localparam int CHUNK_BYTES     = 8;

   localparam int LEN_W    = 11;
   localparam int OFFSET_W = 8;
   localparam int SETUP_W  = 64;

   // largest data stage that still fits in the descriptor budget
   localparam int MAX_DATA_BYTES = (MAX_DESCRIPTORS - 2) * CHUNK_BYTES;
   localparam int CMP_W          = 13;

   localparam logic [LEN_W-1:0] LEN_LIMIT = 11'd1024;
   localparam logic [LEN_W-1:0] LEN_NONE  = 11'h7FF;
   localparam logic [LEN_W-1:0] CHUNK_LEN = LEN_W'(CHUNK_BYTES);
   localparam logic [LEN_W-1:0] SETUP_LEN = 11'd8;

   localparam logic [31:0] ST_ACTIVE = 32'h0080_0000;
   localparam logic [31:0] ST_IOC    = 32'h0100_0000;
   localparam logic [31:0] ST_LS     = 32'h0400_0000;
   localparam logic [31:0] ST_CERR3  = 32'h1800_0000;

   localparam logic [7:0] PID_OUT   = 8'hE1;
   localparam logic [7:0] PID_IN    = 8'h69;
   localparam logic [7:0] PID_SETUP = 8'h2D;

   localparam logic [1:0] KIND_SETUP  = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DATA,
      ST_STATUS,
      ST_REJECT
   } state_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             toggle;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] offset;
      logic             last;
   } stage_ctrl_type;

   function automatic logic [31:0] make_token(input logic [7:0] pid,
                                              input logic [6:0] addr,
                                              input logic toggle,
                                              input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] maxlen;
      maxlen = (len == '0) ? LEN_NONE : (len - LEN_W'(1));
      return {maxlen, 1'b0, toggle, 4'd0, addr, pid};
   endfunction

endpackage

// ===== rtl/usbcdb_fmt.sv =====
// Descriptor word formatter: builds token, status and setup fields of one
// result word from the sequencer's stage control. Depends on usbcdb_pkg.
module usbcdb_fmt (
   input  usbcdb_pkg::stage_ctrl_type    ctrl,
   input  logic                          slow_device,
   input  logic [6:0]                    device_address,
   input  logic                          direction_in,
   input  logic [usbcdb_pkg::SETUP_W-1:0] setup_packet,
   output logic [1:0]                    stage_kind,
   output logic [31:0]                   token_word,
   output logic [31:0]                   status_word,
   output logic [usbcdb_pkg::OFFSET_W-1:0] buffer_offset,
   output logic [usbcdb_pkg::SETUP_W-1:0] setup_bytes,
   output logic                          last
);

   logic [7:0]  pid;
   logic [31:0] base;

   assign base = usbcdb_pkg::ST_ACTIVE | usbcdb_pkg::ST_CERR3 |
                 (slow_device ? usbcdb_pkg::ST_LS : 32'd0);

   always_comb begin
      pid           = usbcdb_pkg::PID_SETUP;
      token_word    = '0;
      status_word   = '0;
      buffer_offset = '0;
      setup_bytes   = '0;
      case (ctrl.kind)
         usbcdb_pkg::KIND_SETUP: begin
            pid         = usbcdb_pkg::PID_SETUP;
            status_word = base;
            setup_bytes = setup_packet;
         end
         usbcdb_pkg::KIND_DATA: begin
            pid           = direction_in ? usbcdb_pkg::PID_IN : usbcdb_pkg::PID_OUT;
            status_word   = base;
            buffer_offset = ctrl.offset[usbcdb_pkg::OFFSET_W-1:0];
         end
         usbcdb_pkg::KIND_STATUS: begin
            // status stage runs opposite to the data stage
            pid         = direction_in ? usbcdb_pkg::PID_OUT : usbcdb_pkg::PID_IN;
            status_word = base | usbcdb_pkg::ST_IOC;
         end
         default: begin
            pid = usbcdb_pkg::PID_SETUP;
         end
      endcase
      if (ctrl.kind != usbcdb_pkg::KIND_REJECT) begin
         token_word = usbcdb_pkg::make_token(pid, device_address, ctrl.toggle, ctrl.len);
      end
   end

   assign stage_kind = ctrl.kind;
   assign last       = ctrl.last;

endmodule

// ===== rtl/usb_control_descriptor_builder.sv =====
// Control-transfer descriptor builder, top level: request capture, stage
// sequencer and shared chunk subtract/compare. Depends on usbcdb_pkg, usbcdb_fmt.
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_stall   one control request
//   rsp_     out  rsp_valid/rsp_stall   one descriptor word
//
// A request of N data descriptors gives N+2 words, one per cycle while rsp_stall
// is low, and the next request is taken in the cycle after the last word leaves.
// A rejected request gives one word. The rate is set by the sequencer's single
// subtract/compare unit, which cuts one chunk per word. A stall holds the current
// word; reset returns to idle.
module usb_control_descriptor_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_slow_device,
   input  logic [6:0]  req_device_address,
   input  logic [7:0]  req_request_kind,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_index,
   input  logic [10:0] req_data_length,
   input  logic        req_direction_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_stage_kind,
   output logic [31:0] rsp_token_word,
   output logic [31:0] rsp_status_word,
   output logic [7:0]  rsp_buffer_offset,
   output logic [63:0] rsp_setup_bytes,
   output logic        rsp_last
);

   localparam int LW = usbcdb_pkg::LEN_W;

   usbcdb_pkg::state_type state_ff, state_in;

   logic                          ls_ff;
   logic [6:0]                    addr_ff;
   logic                          dir_ff;
   logic [usbcdb_pkg::SETUP_W-1:0] setup_ff;
   logic [LW-1:0]                 remaining_ff, remaining_in;
   logic [LW-1:0]                 done_ff, done_in;
   logic                          toggle_ff, toggle_in;

   logic          req_take;
   logic          rsp_take;
   logic          reject;
   logic          fits;
   logic [LW-1:0] chunk;
   usbcdb_pkg::stage_ctrl_type ctrl;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   assign reject = (req_data_length > usbcdb_pkg::LEN_LIMIT) ||
                   ({2'b0, req_data_length} >
                    usbcdb_pkg::CMP_W'(usbcdb_pkg::MAX_DATA_BYTES));

   // shared unit: size of the next chunk and whether it is the final one
   assign fits  = (remaining_ff <= usbcdb_pkg::CHUNK_LEN);
   assign chunk = fits ? remaining_ff : usbcdb_pkg::CHUNK_LEN;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         usbcdb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = reject ? usbcdb_pkg::ST_REJECT : usbcdb_pkg::ST_SETUP;
            end
         end
         usbcdb_pkg::ST_SETUP: begin
            if (rsp_take) begin
               state_in = (remaining_ff == '0) ? usbcdb_pkg::ST_STATUS
                                               : usbcdb_pkg::ST_DATA;
            end
         end
         usbcdb_pkg::ST_DATA: begin
            if (rsp_take && fits) begin
               state_in = usbcdb_pkg::ST_STATUS;
            end
         end
         usbcdb_pkg::ST_STATUS,
         usbcdb_pkg::ST_REJECT: begin
            if (rsp_take) begin
               state_in = usbcdb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = usbcdb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b1;
      ctrl.kind   = usbcdb_pkg::KIND_SETUP;
      ctrl.toggle = 1'b0;
      ctrl.len    = usbcdb_pkg::SETUP_LEN;
      ctrl.offset = '0;
      ctrl.last   = 1'b0;
      case (state_ff)
         usbcdb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            rsp_valid = 1'b0;
         end
         usbcdb_pkg::ST_SETUP: begin
            ctrl.kind = usbcdb_pkg::KIND_SETUP;
         end
         usbcdb_pkg::ST_DATA: begin
            ctrl.kind   = usbcdb_pkg::KIND_DATA;
            ctrl.toggle = toggle_ff;
            ctrl.len    = chunk;
            ctrl.offset = done_ff;
         end
         usbcdb_pkg::ST_STATUS: begin
            ctrl.kind   = usbcdb_pkg::KIND_STATUS;
            ctrl.toggle = 1'b1;
            ctrl.len    = '0;
            ctrl.last   = 1'b1;
         end
         usbcdb_pkg::ST_REJECT: begin
            ctrl.kind = usbcdb_pkg::KIND_REJECT;
            ctrl.len  = '0;
            ctrl.last = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      remaining_in = remaining_ff;
      done_in      = done_ff;
      toggle_in    = toggle_ff;
      if (req_take) begin
         remaining_in = req_data_length;
         done_in      = '0;
         toggle_in    = 1'b1;
      end else if (rsp_take && (state_ff == usbcdb_pkg::ST_DATA)) begin
         remaining_in = remaining_ff - chunk;
         done_in      = done_ff + chunk;
         toggle_in    = ~toggle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usbcdb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
      done_ff      <= done_in;
      toggle_ff    <= toggle_in;
      if (req_take) begin
         ls_ff    <= req_slow_device;
         addr_ff  <= req_device_address;
         dir_ff   <= req_direction_in;
         setup_ff <= {5'd0, req_data_length, req_request_index, req_request_value,
                      req_request_code, req_request_kind};
      end
   end

   usbcdb_fmt u_fmt (
      .ctrl           (ctrl),
      .slow_device    (ls_ff),
      .device_address (addr_ff),
      .direction_in   (dir_ff),
      .setup_packet   (setup_ff),
      .stage_kind     (rsp_stage_kind),
      .token_word     (rsp_token_word),
      .status_word    (rsp_status_word),
      .buffer_offset  (rsp_buffer_offset),
      .setup_bytes    (rsp_setup_bytes),
      .last           (rsp_last)
   );

endmodule
